// File: src/tpdd_pkg.sv
// shared types and constants of the throttle pulse dac drive
`default_nettype none

package tpdd_pkg;

  localparam int FULL_SCALE_DEFAULT = 180;
  localparam int CMD_DEPTH_DEFAULT  = 4;
  localparam int RES_DEPTH_DEFAULT  = 2;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VOLTAGE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_VOLTAGE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LENGTH   = 2'd2;

  localparam logic [7:0] MAX_VOLTAGE_RESET    = 8'd180;
  localparam logic [7:0] CUTOFF_VOLTAGE_RESET = 8'd40;
  localparam logic [7:0] PULSE_LENGTH_RESET   = 8'd75;

  localparam logic [1:0] MODE_SPEED = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_DAC   = 2'd2;

  localparam logic [7:0] LEVEL_MAX      = 8'hFF;
  localparam logic [6:0] SPEED_MAX      = 7'd127;
  localparam logic [3:0] DAC_CMD_NIBBLE = 4'h3;

  localparam int DIV_BITS = 16;

  typedef enum logic [1:0] {
    K_SPEED,
    K_FRAME,
    K_DAC
  } kind_t;

  typedef enum logic [1:0] {
    D_KEEP,
    D_SET,
    D_CLR
  } dir_op_t;

  typedef struct packed {
    kind_t      kind;
    logic       channel;
    logic [6:0] speed;
    dir_op_t    dir_op;
  } cmd_t;

  typedef struct packed {
    logic [7:0] dac_byte;
    logic       dac_channel;
    logic       word_start;
    logic       relay_a;
    logic       relay_b;
  } res_t;

  typedef struct packed {
    logic [7:0] max_voltage;
    logic [7:0] cutoff_voltage;
    logic [7:0] pulse_length;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/throttle_pulse_dac_drive_core.sv
// Two-channel analog throttle drive with boost pulses and a serial dac byte stream.
//
// Items go in through a queue port: an item transfers when push is high and full
// is low. mode 0 is a speed command, mode 1 a frame tick, mode 2 a dac tick;
// mode 3 is dropped. Only a dac tick yields a result, which waits in an output
// queue and transfers when pop is high and empty is low.
// Accepted items enter a four-entry command queue; the execution side handles
// them in order. Frame and dac ticks are handled in the cycle in which they
// leave that queue, and a dac tick's byte is then registered in the result
// queue before it reaches the result ports. A speed command runs at most six
// scalings: those by constants use a reciprocal multiply, the one by the cutoff
// voltage a shift-subtract divider. It holds the execution side until its last
// scaling is done; without a boost pulse it stops after the cutoff comparison.
// When nobody pops results the two-entry result queue fills, dac ticks wait at
// the head of the command queue, and full rises once that queue is full too.
// Registers are written through cfg_write, cfg_index and cfg_data, by the user
// only while idle (not enforced by the block); index 3 is ignored. Synchronous
// reset rst clears all channel state, empties both queues and loads the register defaults.
`default_nettype none

module throttle_pulse_dac_drive_core #(
  parameter int FULL_SCALE_DECIVOLTS = tpdd_pkg::FULL_SCALE_DEFAULT,
  parameter int CMD_DEPTH            = tpdd_pkg::CMD_DEPTH_DEFAULT,
  parameter int RES_DEPTH            = tpdd_pkg::RES_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       mode,
  input  logic                             channel,
  input  logic [7:0]                       speed,
  input  logic [7:0]                       direction,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       dac_byte,
  output logic                             dac_channel,
  output logic                             word_start,
  output logic                             relay_a,
  output logic                             relay_b,
  input  logic                             cfg_write,
  input  logic [tpdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  import tpdd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  logic cmd_empty;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_voltage    <= MAX_VOLTAGE_RESET;
      cfg.cutoff_voltage <= CUTOFF_VOLTAGE_RESET;
      cfg.pulse_length   <= PULSE_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_VOLTAGE:    cfg.max_voltage    <= cfg_data;
        CFG_CUTOFF_VOLTAGE: cfg.cutoff_voltage <= cfg_data;
        CFG_PULSE_LENGTH:   cfg.pulse_length   <= cfg_data;
        default:            cfg <= cfg;
      endcase
    end
  end

  tpdd_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .channel  (channel),
    .speed    (speed),
    .direction(direction),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  tpdd_back #(
    .FULL_SCALE_DECIVOLTS(FULL_SCALE_DECIVOLTS),
    .RES_DEPTH           (RES_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .res_empty(empty),
    .res_pop  (pop),
    .res      (res)
  );

  assign dac_byte    = res.dac_byte;
  assign dac_channel = res.dac_channel;
  assign word_start  = res.word_start;
  assign relay_a     = res.relay_a;
  assign relay_b     = res.relay_b;

endmodule

`default_nettype wire

// File: src/tpdd_fifo.sv
// small register based first-in first-out queue
`default_nettype none

module tpdd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/tpdd_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module tpdd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);

  import tpdd_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic [15:0]      dvd;
  logic [7:0]       rem;
  logic [7:0]       dvsr;
  logic [CNT_W-1:0] cnt;
  logic [8:0]       trial;
  logic             ge;

  assign trial    = {rem, dvd[15]};
  assign ge       = (trial >= {1'b0, dvsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= '0;
      rem  <= '0;
      dvsr <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dvsr <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // quotient bits shift in where dividend bits leave
        rem <= ge ? 8'(trial - {1'b0, dvsr}) : trial[7:0];
        dvd <= {dvd[14:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/tpdd_front.sv
// input side: decodes items and queues them as commands
`default_nettype none

module tpdd_front #(
  parameter int CMD_DEPTH = tpdd_pkg::CMD_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      mode,
  input  logic            channel,
  input  logic [7:0]      speed,
  input  logic [7:0]      direction,
  output logic            cmd_empty,
  input  logic            cmd_pop,
  output tpdd_pkg::cmd_t  cmd
);

  import tpdd_pkg::*;

  cmd_t                   cmd_in;
  logic                   known;
  logic [$bits(cmd_t)-1:0] q_dout;

  always_comb begin
    cmd_in         = '0;
    known          = 1'b1;
    cmd_in.channel = channel;
    case (mode)
      MODE_SPEED: cmd_in.kind = K_SPEED;
      MODE_FRAME: cmd_in.kind = K_FRAME;
      MODE_DAC:   cmd_in.kind = K_DAC;
      default: begin
        cmd_in.kind = K_FRAME;
        known       = 1'b0;
      end
    endcase
    // stop forces zero speed and keeps the relay
    if (direction == 8'd0) begin
      cmd_in.speed  = '0;
      cmd_in.dir_op = D_KEEP;
    end else begin
      cmd_in.speed = (speed > {1'b0, SPEED_MAX}) ? SPEED_MAX : speed[6:0];
      if (direction[0]) begin
        cmd_in.dir_op = D_SET;
      end else if (direction[1]) begin
        cmd_in.dir_op = D_CLR;
      end else begin
        cmd_in.dir_op = D_KEEP;
      end
    end
  end

  tpdd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && known),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (q_dout),
    .empty(cmd_empty)
  );

  assign cmd = cmd_t'(q_dout);

endmodule

`default_nettype wire

// File: src/tpdd_back.sv
// execution side: channel state, speed arithmetic, dac stream and result queue
`default_nettype none

module tpdd_back #(
  parameter int FULL_SCALE_DECIVOLTS = tpdd_pkg::FULL_SCALE_DEFAULT,
  parameter int RES_DEPTH            = tpdd_pkg::RES_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tpdd_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  tpdd_pkg::cmd_t cmd,
  output logic           res_empty,
  input  logic           res_pop,
  output tpdd_pkg::res_t res
);

  import tpdd_pkg::*;

  localparam logic [7:0] FULL8 = 8'(FULL_SCALE_DECIVOLTS);

  // dividends stay below 2^16 and divisors below 2^8, so a 24-bit shift is exact
  localparam int RCP_SHIFT = 24;
  localparam logic [24:0] RCP_FULL  =
    25'(((1 << RCP_SHIFT) + FULL_SCALE_DECIVOLTS - 1) / FULL_SCALE_DECIVOLTS);
  localparam logic [24:0] RCP_SPEED =
    25'(((1 << RCP_SHIFT) + int'(SPEED_MAX) - 1) / int'(SPEED_MAX));
  localparam logic [24:0] RCP_LEVEL =
    25'(((1 << RCP_SHIFT) + int'(LEVEL_MAX) - 1) / int'(LEVEL_MAX));

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_WAIT
  } state_t;

  typedef enum logic [2:0] {
    ST_TOP,
    ST_BASE,
    ST_CUT,
    ST_VOUT,
    ST_PV,
    ST_PL
  } step_t;

  state_t     state;
  step_t      step;

  logic [7:0] base_level      [2];
  logic [7:0] pulse_level     [2];
  logic [7:0] pulse_len_set   [2];
  logic [7:0] pulse_countdown [2];
  logic [1:0] dac_phase;
  logic [7:0] held_level;
  logic [1:0] relay_bits;

  logic       ch;
  logic [6:0] spd;
  logic [7:0] top;
  logic [7:0] base;
  logic [7:0] vout;
  logic [7:0] vp;
  logic [15:0] prod;
  logic [15:0] qr;

  logic [7:0] vmax;
  logic       diff_neg;
  logic [7:0] diff_mag;
  logic [7:0] mul_a;
  logic [7:0] mul_b;
  logic [24:0] rcp;
  logic [40:0] rcp_prod;

  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] q;
  logic        q_ready;
  logic [7:0]  q_sat;
  logic [16:0] vp_sum;
  logic [7:0]  vp_clamped;

  logic       cmd_valid;
  logic       res_full;
  logic       res_push;
  res_t       res_in;
  logic       dch;
  logic       first;
  logic [7:0] lvl_sel;

  assign vmax     = (cfg.max_voltage > FULL8) ? FULL8 : cfg.max_voltage;
  assign diff_neg = (cfg.cutoff_voltage < vmax);
  assign diff_mag = diff_neg ? 8'(vmax - cfg.cutoff_voltage)
                             : 8'(cfg.cutoff_voltage - vmax);

  always_comb begin
    case (step)
      ST_TOP:  begin mul_a = LEVEL_MAX; mul_b = vmax;               rcp = RCP_FULL;  end
      ST_BASE: begin mul_a = top;       mul_b = {1'b0, spd};        rcp = RCP_SPEED; end
      ST_CUT:  begin mul_a = LEVEL_MAX; mul_b = cfg.cutoff_voltage; rcp = RCP_FULL;  end
      ST_VOUT: begin mul_a = base;      mul_b = FULL8;              rcp = RCP_LEVEL; end
      ST_PV:   begin mul_a = vout;      mul_b = diff_mag;           rcp = RCP_FULL;  end
      ST_PL:   begin mul_a = LEVEL_MAX; mul_b = vp;                 rcp = RCP_FULL;  end
      default: begin mul_a = '0;        mul_b = '0;                 rcp = RCP_FULL;  end
    endcase
  end

  // constant divisors by reciprocal multiply, only the cutoff goes through the divider
  assign rcp_prod = {25'b0, prod} * {16'b0, rcp};
  assign q        = (step == ST_PV) ? div_q : qr;
  assign q_ready  = (step == ST_PV) ? div_done : 1'b1;

  assign q_sat  = (q > {8'b0, LEVEL_MAX}) ? LEVEL_MAX : q[7:0];
  assign vp_sum = {1'b0, q} + {9'b0, vmax};

  // pulse voltage clamped to one byte, quotient truncated toward zero
  always_comb begin
    if (diff_neg) begin
      vp_clamped = (q > {8'b0, vmax}) ? 8'd0 : 8'(vmax - q[7:0]);
    end else begin
      vp_clamped = (vp_sum > 17'(LEVEL_MAX)) ? LEVEL_MAX : vp_sum[7:0];
    end
  end

  assign div_start = (state == S_DIVGO) && (step == ST_PV);

  tpdd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (cfg.cutoff_voltage),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  // dac tick result
  assign dch     = dac_phase[1];
  assign first   = !dac_phase[0];
  assign lvl_sel = (pulse_countdown[dch] != 8'd0) ? pulse_level[dch] : base_level[dch];

  always_comb begin
    res_in.dac_byte    = first ? {DAC_CMD_NIBBLE, lvl_sel[7:4]} : {held_level[3:0], 4'h0};
    res_in.dac_channel = dch;
    res_in.word_start  = first;
    res_in.relay_a     = relay_bits[0];
    res_in.relay_b     = relay_bits[1];
  end

  assign cmd_valid = !cmd_empty;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid && !((cmd.kind == K_DAC) && res_full);
  assign res_push  = cmd_pop && (cmd.kind == K_DAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= ST_TOP;
      for (int i = 0; i < 2; i++) begin
        base_level[i]      <= '0;
        pulse_level[i]     <= '0;
        pulse_len_set[i]   <= '0;
        pulse_countdown[i] <= '0;
      end
      dac_phase  <= '0;
      held_level <= '0;
      relay_bits <= '0;
      ch         <= 1'b0;
      spd        <= '0;
      top        <= '0;
      base       <= '0;
      vout       <= '0;
      vp         <= '0;
      prod       <= '0;
      qr         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              K_SPEED: begin
                case (cmd.dir_op)
                  D_SET:   relay_bits[cmd.channel] <= 1'b1;
                  D_CLR:   relay_bits[cmd.channel] <= 1'b0;
                  default: relay_bits <= relay_bits;
                endcase
                ch    <= cmd.channel;
                spd   <= cmd.speed;
                step  <= ST_TOP;
                state <= S_MUL;
              end
              K_FRAME: begin
                for (int i = 0; i < 2; i++) begin
                  if (pulse_level[i] != 8'd0 && pulse_len_set[i] != 8'd0) begin
                    pulse_countdown[i] <= pulse_len_set[i];
                  end
                end
              end
              K_DAC: begin
                if (first) begin
                  held_level <= lvl_sel;
                end
                dac_phase <= dac_phase + 1'b1;
                for (int i = 0; i < 2; i++) begin
                  if (pulse_countdown[i] != 8'd0) begin
                    pulse_countdown[i] <= pulse_countdown[i] - 1'b1;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          prod  <= {8'b0, mul_a} * {8'b0, mul_b};
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          qr    <= rcp_prod[RCP_SHIFT+15:RCP_SHIFT];
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (q_ready) begin
            state <= S_MUL;
            case (step)
              ST_TOP: begin
                top  <= q[7:0];
                step <= ST_BASE;
              end
              ST_BASE: begin
                base           <= q[7:0];
                base_level[ch] <= q[7:0];
                step           <= ST_CUT;
              end
              ST_CUT: begin
                if (base != 8'd0 && base < q_sat && cfg.cutoff_voltage != 8'd0) begin
                  step <= ST_VOUT;
                end else begin
                  pulse_level[ch]   <= '0;
                  pulse_len_set[ch] <= '0;
                  state             <= S_IDLE;
                end
              end
              ST_VOUT: begin
                vout <= q[7:0];
                step <= ST_PV;
              end
              ST_PV: begin
                vp   <= vp_clamped;
                step <= ST_PL;
              end
              ST_PL: begin
                pulse_level[ch]   <= q_sat;
                pulse_len_set[ch] <= cfg.pulse_length;
                state             <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tpdd_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (res_pop),
    .dout (res),
    .empty(res_empty)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_speed_starts_math: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == K_SPEED) |=> (state == S_MUL && step == ST_TOP))
    else $error("speed command did not start its arithmetic");

  a_div_free_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd_pop)
    else $error("command taken during arithmetic");

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking bench for the throttle pulse dac drive core: scoreboard class and top module
`timescale 1ns / 100ps

import tpdd_pkg::*;

class dac_stream_scoreboard;
  logic [7:0] max_v, cut_v, plen;
  logic [7:0] base_lvl [2];
  logic [7:0] pulse_lvl [2];
  logic [7:0] pulse_len [2];
  logic [7:0] countdown [2];
  logic [1:0] phase;
  logic [7:0] held;
  logic [1:0] relays;
  res_t byte_q [$];
  int faults, checked;
  int speed_cmds, boost_cmds, frame_ticks;

  function new();
    max_v = MAX_VOLTAGE_RESET;
    cut_v = CUTOFF_VOLTAGE_RESET;
    plen = PULSE_LENGTH_RESET;
    for (int i = 0; i < 2; i++) begin
      base_lvl[i] = '0;
      pulse_lvl[i] = '0;
      pulse_len[i] = '0;
      countdown[i] = '0;
    end
    phase = '0;
    held = '0;
    relays = '0;
  endfunction

  function int pending();
    return byte_q.size();
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
    case (idx)
      CFG_MAX_VOLTAGE: max_v = val;
      CFG_CUTOFF_VOLTAGE: cut_v = val;
      CFG_PULSE_LENGTH: plen = val;
      default: ;
    endcase
  endfunction

  // decivolts to dac level, saturating
  function int level_of_dv(int dv);
    int v;
    v = 255 * dv / FULL_SCALE_DEFAULT;
    return (v > int'(LEVEL_MAX)) ? int'(LEVEL_MAX) : v;
  endfunction

  function int volts_of_level(int lvl);
    return lvl * FULL_SCALE_DEFAULT / 255;
  endfunction

  function void apply_speed(logic ch, logic [7:0] spd_in);
    int vmax, cut, spd, top, base, vout, vp;
    vmax = max_v;
    cut = cut_v;
    spd = spd_in;
    if (vmax > FULL_SCALE_DEFAULT) vmax = FULL_SCALE_DEFAULT;
    if (spd > int'(SPEED_MAX)) spd = int'(SPEED_MAX);
    top = level_of_dv(vmax);
    base = top * spd / int'(SPEED_MAX);
    base_lvl[ch] = base[7:0];
    if (base != 0 && base < level_of_dv(cut) && cut != 0) begin
      // boost voltage moves toward vmax as the output drops; signed, truncating
      vout = volts_of_level(base);
      vp = vout * (cut - vmax) / cut + vmax;
      if (vp < 0) vp = 0;
      if (vp > 255) vp = 255;
      vp = level_of_dv(vp);
      pulse_lvl[ch] = vp[7:0];
      pulse_len[ch] = plen;
      boost_cmds++;
    end else begin
      pulse_lvl[ch] = '0;
      pulse_len[ch] = '0;
    end
  endfunction

  function void note_item(logic [1:0] m, logic ch, logic [7:0] spd, logic [7:0] dir);
    res_t r;
    logic dch, first;
    case (m)
      MODE_SPEED: begin
        speed_cmds++;
        if (dir == 8'd0) apply_speed(ch, 8'd0);
        else begin
          if (dir[0]) relays[ch] = 1'b1;
          else if (dir[1]) relays[ch] = 1'b0;
          apply_speed(ch, spd);
        end
      end
      MODE_FRAME: begin
        frame_ticks++;
        for (int i = 0; i < 2; i++)
          if (pulse_lvl[i] != 0 && pulse_len[i] != 0) countdown[i] = pulse_len[i];
      end
      MODE_DAC: begin
        dch = phase[1];
        first = !phase[0];
        if (first) begin
          held = (countdown[dch] != 0) ? pulse_lvl[dch] : base_lvl[dch];
          r.dac_byte = {DAC_CMD_NIBBLE, held[7:4]};
        end else begin
          r.dac_byte = {held[3:0], 4'h0};
        end
        r.dac_channel = dch;
        r.word_start = first;
        r.relay_a = relays[0];
        r.relay_b = relays[1];
        byte_q.push_back(r);
        phase = phase + 2'd1;
        for (int i = 0; i < 2; i++)
          if (countdown[i] != 0) countdown[i] = countdown[i] - 8'd1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (byte_q.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("%0t: dac byte %h arrived with nothing expected", $time, got.dac_byte);
      return;
    end
    want = byte_q.pop_front();
    checked++;
    if (got.dac_byte !== want.dac_byte || got.dac_channel !== want.dac_channel ||
        got.word_start !== want.word_start || got.relay_a !== want.relay_a ||
        got.relay_b !== want.relay_b) begin
      faults++;
      if (faults <= 10)
        $display("%0t: mismatch exp byte %h ch %b start %b relays %b%b, got %h %b %b %b%b",
                 $time, want.dac_byte, want.dac_channel, want.word_start, want.relay_a,
                 want.relay_b, got.dac_byte, got.dac_channel, got.word_start,
                 got.relay_a, got.relay_b);
    end
  endfunction
endclass

module tb;
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam int DRAIN_LIMIT = 50000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int TIMEOUT_NS = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] mode = MODE_SPEED;
  logic channel = 1'b0;
  logic [7:0] speed = 8'd0;
  logic [7:0] direction = 8'd0;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAX_VOLTAGE;
  logic [7:0] cfg_data = 8'd0;
  logic full, empty, dac_channel, word_start, relay_a, relay_b;
  logic [7:0] dac_byte;

  dac_stream_scoreboard sb;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int full_cycles = 0;
  int items_sent = 0;
  int settings = 1;

  always #5 clk = ~clk;

  throttle_pulse_dac_drive_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .mode(mode), .channel(channel), .speed(speed), .direction(direction),
    .empty(empty), .pop(pop),
    .dac_byte(dac_byte), .dac_channel(dac_channel), .word_start(word_start),
    .relay_a(relay_a), .relay_b(relay_b),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_item(input logic [1:0] m, input logic ch,
                           input logic [7:0] spd, input logic [7:0] dir);
    int gap;
    push <= 1'b1;
    mode <= m;
    channel <= ch;
    speed <= spd;
    direction <= dir;
    do begin
      @(posedge clk);
      if (full) full_cycles++;
    end while (full);
    sb.note_item(m, ch, spd, dir);
    if (m != MODE_IGNORED) items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, let every expected byte come out, then cover queued speed commands
  task automatic wait_idle();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] mv, input logic [7:0] cv,
                              input logic [7:0] pl, input bit poke_unused);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [7:0] vals [4];
    int n;
    idx = '{CFG_MAX_VOLTAGE, CFG_CUTOFF_VOLTAGE, CFG_PULSE_LENGTH, CFG_UNUSED_INDEX};
    vals = '{mv, cv, pl, 8'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
    settings++;
  endtask

  initial begin : result_side
    int stall, hold;
    res_t got;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.dac_byte = dac_byte;
        got.dac_channel = dac_channel;
        got.word_start = word_start;
        got.relay_a = relay_a;
        got.relay_b = relay_b;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        stall = gap_len();
        pop <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int r, start;
    logic [7:0] spd, dir;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset register values
    send_item(MODE_SPEED, 1'b0, 8'd10, 8'h01);   // low speed sets relay a, arms a boost
    send_item(MODE_FRAME, 1'b0, 8'd0, 8'h00);
    repeat (4) send_item(MODE_DAC, 1'b0, 8'd0, 8'h00);
    send_item(MODE_SPEED, 1'b1, 8'd255, 8'h03);  // speed above the top step is clamped
    send_item(MODE_SPEED, 1'b1, 8'd127, 8'h82);  // bit 1 alone clears the relay
    send_item(MODE_SPEED, 1'b0, 8'd200, 8'h00);  // stop: speed forced to zero, relay kept
    send_item(MODE_SPEED, 1'b0, 8'd1, 8'hFC);    // neither relay bit: relay kept
    send_item(MODE_IGNORED, 1'b1, 8'hFF, 8'hFF);
    send_item(MODE_FRAME, 1'b1, 8'hFF, 8'hFF);
    repeat (8) send_item(MODE_DAC, 1'b1, 8'hFF, 8'hFF);
    send_item(MODE_SPEED, 1'b1, 8'd0, 8'hFF);    // zero base level, no pulse
    send_item(MODE_SPEED, 1'b0, 8'd27, 8'h01);   // just under the cutoff threshold
    send_item(MODE_FRAME, 1'b0, 8'd0, 8'h00);
    repeat (2) send_item(MODE_DAC, 1'b0, 8'd0, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_regs(8'd0, 8'd180, 8'd255, 1'b0);   // no drive at all
        1: program_regs(8'd255, 8'd255, 8'd1, 1'b1);   // both above full scale
        2: program_regs(8'd60, 8'd150, 8'd20, 1'b0);
        3: program_regs(8'd180, 8'd120, 8'd0, 1'b0);   // pulse length zero
        4: program_regs(8'd100, 8'd0, 8'd200, 1'b1);   // cutoff zero
        5: program_regs(8'd30, 8'd180, 8'd9, 1'b0);    // boost on nearly every step
        6: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        default: program_regs(MAX_VOLTAGE_RESET, CUTOFF_VOLTAGE_RESET,
                              PULSE_LENGTH_RESET, 1'b0);
      endcase
      steady = (ph == 3);
      // long receiver hold-off while transfers keep coming in
      if (ph == 2) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          r = $urandom_range(0, 99);
          if (r < 45) spd = 8'($urandom_range(0, 40));
          else if (r < 60) spd = 8'($urandom_range(120, 255));
          else spd = 8'($urandom);
          dir = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom);
          send_item(MODE_SPEED, 1'($urandom), spd, dir);
          if ($urandom_range(0, 3) != 0)
            send_item(MODE_FRAME, 1'($urandom), 8'($urandom), 8'($urandom));
          repeat ($urandom_range(2, 12))
            send_item(MODE_DAC, 1'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    steady = 1'b0;

    wait_idle();
    if (sb.pending() > 0) begin
      $display("%0d expected dac bytes never arrived", sb.pending());
      sb.faults += sb.pending();
    end
    $display("ran %0d items over %0d register settings: %0d speed commands, %0d with boost,",
             items_sent, settings, sb.speed_cmds, sb.boost_cmds);
    $display("%0d frame ticks, %0d dac bytes checked, input held off %0d cycles by full",
             sb.frame_ticks, sb.checked, full_cycles);
    if (sb.faults == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
